[rtl/psr_pkg.sv]
// ----------------------------------------------------------------------------
// psr_pkg
// Shared types, constants and helpers of the particle systematic resampler.
// ----------------------------------------------------------------------------
`default_nettype none

package psr_pkg;

  localparam int MAX_P        = 32;
  localparam int IW           = 5;
  localparam int NW           = 6;
  localparam int OFF_BITS     = 16;
  localparam int HIST_LEN     = 3;
  localparam int HSUM_W       = 7;
  localparam int DEF_WEIGHT_BITS = 32;
  localparam logic [NW-1:0] RST_COUNT = NW'(10);
  localparam logic [NW-1:0] RST_SIZE  = NW'(10);

  typedef enum logic [1:0] {
    KIND_SUMMARY = 2'd0,
    KIND_KEEP    = 2'd1,
    KIND_COPY    = 2'd2
  } kind_t;

  // one round handed from the front to the back
  typedef struct packed {
    logic [NW-1:0]       n;
    logic [NW-1:0]       loaded;
    logic [OFF_BITS-1:0] off;
  } job_t;

  // back to front handshake
  typedef struct packed {
    logic take;
    logic release_ram;
  } bk2fe_t;

  // one result item
  typedef struct packed {
    kind_t             kind;
    logic [IW-1:0]     target;
    logic [IW-1:0]     source;
    logic [NW-1:0]     size;
    logic [HSUM_W-1:0] sum3;
    logic              zero;
    logic              res;
    logic              last;
  } res_t;

  // count register as used: zero acts as one, big values saturate
  function automatic logic [NW-1:0] clamp_count(input logic [NW-1:0] c);
    logic [NW-1:0] r;
    r = c;
    if (c == '0) r = NW'(1);
    if (c > NW'(MAX_P)) r = NW'(MAX_P);
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/psr_ram.sv]
// ----------------------------------------------------------------------------
// psr_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module psr_ram #(
  parameter int W = 32,
  parameter int D = 32
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [$clog2(D)-1:0] waddr,
  input  wire logic [W-1:0]         wdata,
  input  wire logic [$clog2(D)-1:0] raddr,
  output logic      [W-1:0]         rdata
);

  logic [W-1:0] mem_r [D];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

`default_nettype wire

[rtl/psr_mul.sv]
// ----------------------------------------------------------------------------
// psr_mul
// Shift-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module psr_mul #(
  parameter int W = 37
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  input  wire logic [W-1:0]   a,
  input  wire logic [W-1:0]   b,
  output logic                done,
  output logic      [2*W-1:0] prod
);

  localparam int CW = $clog2(W + 1);

  logic           busy_r;
  logic [CW-1:0]  cnt_r;
  logic [2*W-1:0] mc_r;
  logic [W-1:0]   mp_r;
  logic [2*W-1:0] acc_r;
  logic           done_r;

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == CW'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      cnt_r <= CW'(W);
      mc_r  <= (2*W)'(a);
      mp_r  <= b;
      acc_r <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r - CW'(1);
      mc_r  <= mc_r << 1;
      mp_r  <= mp_r >> 1;
      if (mp_r[0]) begin
        acc_r <= acc_r + mc_r;
      end
    end
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

`default_nettype wire

[rtl/psr_front.sv]
// ----------------------------------------------------------------------------
// psr_front
// Accepts weight items, fills the weight RAM and queues one round job.
// ----------------------------------------------------------------------------
`default_nettype none

module psr_front
  import psr_pkg::*;
#(
  parameter int WEIGHT_BITS = DEF_WEIGHT_BITS
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_push,
  input  wire logic [WEIGHT_BITS-1:0] in_weight,
  input  wire logic [OFF_BITS-1:0]    in_offset,
  input  wire logic                   in_last_weight,
  output logic                        in_full,
  input  wire logic [NW-1:0]          count,
  output logic                        ram_we,
  output logic      [IW-1:0]          ram_waddr,
  output logic      [WEIGHT_BITS-1:0] ram_wdata,
  output logic                        job_vld,
  output job_t                        job,
  input  wire bk2fe_t                 link
);

  logic [NW-1:0] load_count_r;
  logic          job_vld_r;
  logic          hold_r;
  job_t          job_r;
  logic          acc;
  logic          store;
  logic [NW-1:0] n;

  assign n       = clamp_count(count);
  assign in_full = job_vld_r | hold_r;
  assign acc     = in_push & ~in_full;
  assign store   = load_count_r < n;

  // weight store write
  assign ram_we    = acc & store;
  assign ram_waddr = load_count_r[IW-1:0];
  assign ram_wdata = in_weight;

  // load counter and job queue entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_count_r <= '0;
      job_vld_r    <= 1'b0;
      hold_r       <= 1'b0;
    end else begin
      if (acc) begin
        if (in_last_weight) begin
          load_count_r <= '0;
          job_vld_r    <= 1'b1;
        end else begin
          load_count_r <= load_count_r + NW'(store);
        end
      end
      if (link.take) begin
        job_vld_r <= 1'b0;
        hold_r    <= 1'b1;
      end
      if (link.release_ram) begin
        hold_r <= 1'b0;
      end
    end
  end

  // job payload
  always_ff @(posedge clk) begin
    if (acc && in_last_weight) begin
      job_r.n      <= n;
      job_r.loaded <= load_count_r + NW'(store);
      job_r.off    <= in_offset;
    end
  end

  assign job_vld = job_vld_r;
  assign job     = job_r;

endmodule

`default_nettype wire

[rtl/psr_back.sv]
// ----------------------------------------------------------------------------
// psr_back
// Runs one round: sums, effective size, systematic walk when resampling, and result emit.
// ----------------------------------------------------------------------------
`default_nettype none

module psr_back
  import psr_pkg::*;
#(
  parameter int WEIGHT_BITS = DEF_WEIGHT_BITS
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   job_vld,
  input  wire job_t                   job,
  output bk2fe_t                      link,
  output logic      [IW-1:0]          w_raddr,
  input  wire logic [WEIGHT_BITS-1:0] w_rdata,
  output res_t                        out_item,
  output logic                        out_empty,
  input  wire logic                   out_pop
);

  localparam int WB  = WEIGHT_BITS;
  localparam int SW  = WB + IW;
  localparam int QW  = 2 * WB + IW;
  localparam int NQW = QW + NW;
  localparam int S2W = 2 * SW;
  localparam int EW  = (NQW > S2W) ? NQW : S2W;
  localparam int MW  = (SW > OFF_BITS) ? SW : OFF_BITS;
  localparam int CW  = SW + NW + OFF_BITS + 1;

  typedef enum logic [14:0] {
    ST_IDLE    = 15'b000000000000001,
    ST_S_RD    = 15'b000000000000010,
    ST_S_MUL   = 15'b000000000000100,
    ST_S_ACC   = 15'b000000000001000,
    ST_SQ_GO   = 15'b000000000010000,
    ST_SQ_WAIT = 15'b000000000100000,
    ST_NE      = 15'b000000001000000,
    ST_HIST    = 15'b000000010000000,
    ST_OF_GO   = 15'b000000100000000,
    ST_OF_WAIT = 15'b000001000000000,
    ST_W_RD    = 15'b000010000000000,
    ST_W_MUL   = 15'b000100000000000,
    ST_W_CMP   = 15'b001000000000000,
    ST_SUMM    = 15'b010000000000000,
    ST_EMIT    = 15'b100000000000000
  } state_t;

  state_t state_r, state_nxt;

  logic [NW-1:0]       n_r;
  logic [NW-1:0]       loaded_r;
  logic [OFF_BITS-1:0] off_r;
  logic [IW-1:0]       i_r;
  logic [NW-1:0]       k_r;
  logic [IW-1:0]       j_r;
  logic [SW-1:0]       s_r;
  logic [QW-1:0]       q_r;
  logic [2*WB-1:0]     sq_r;
  logic [S2W-1:0]      s2_r;
  logic [EW-1:0]       qi_r;
  logic [NW-1:0]       neff_r;
  logic                zero_r;
  logic                res_r;
  logic [CW-1:0]       lhs_r;
  logic [SW+NW-1:0]    cn_r;
  logic [MAX_P-1:0]    chosen_r;
  logic [IW-1:0]       dupes_r [MAX_P];
  logic [NW-1:0]       ndup_r;
  logic [IW-1:0]       d_r;
  logic                copy_ph_r;
  logic [NW-1:0]       hist_r [HIST_LEN];

  logic [WB-1:0]       v;
  logic                i_end;
  logic                walk_go;
  logic [CW-1:0]       rhs;
  logic [HSUM_W-1:0]   hsum;
  logic [SW-1:0]       c_rdata;
  logic                mul_start;
  logic [MW-1:0]       mul_a, mul_b;
  logic                mul_done;
  logic [2*MW-1:0]     mul_prod;
  logic                need;
  logic                adv;
  logic                copy_last;
  logic                push;
  res_t                push_item;
  logic                fifo_full;

  assign v       = (NW'(i_r) < loaded_r) ? w_rdata : '0;
  assign i_end   = NW'(i_r) == n_r - NW'(1);
  assign rhs     = CW'(cn_r) << OFF_BITS;
  assign walk_go = ((NW'(j_r) + NW'(1)) < n_r) && (rhs <= lhs_r);
  assign w_raddr = i_r;

  // sum of the size history
  always_comb begin
    hsum = '0;
    for (int h = 0; h < HIST_LEN; h++) begin
      hsum = hsum + HSUM_W'(hist_r[h]);
    end
  end

  // cumulative store
  psr_ram #(.W(SW), .D(MAX_P)) u_cum (
    .clk   (clk),
    .we    (state_r == ST_S_MUL),
    .waddr (i_r),
    .wdata (s_r + SW'(v)),
    .raddr (j_r),
    .rdata (c_rdata)
  );

  // shared serial multiplier for s*s and offset*s
  assign mul_start = (state_r == ST_SQ_GO) || (state_r == ST_OF_GO);
  assign mul_a     = MW'(s_r);
  assign mul_b     = (state_r == ST_OF_GO) ? MW'(off_r) : MW'(s_r);

  psr_mul #(.W(MW)) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  // keep and copy scan
  assign need      = copy_ph_r ? ~chosen_r[i_r] : chosen_r[i_r];
  assign copy_last = (NW'(d_r) + NW'(1)) == ndup_r;
  assign adv       = ~need | ~fifo_full;

  // result push
  always_comb begin
    push             = 1'b0;
    push_item.kind   = KIND_SUMMARY;
    push_item.target = '0;
    push_item.source = '0;
    push_item.size   = neff_r;
    push_item.sum3   = hsum;
    push_item.zero   = zero_r;
    push_item.res    = res_r;
    push_item.last   = 1'b0;
    if (state_r == ST_SUMM) begin
      push           = ~fifo_full;
      push_item.last = ndup_r == '0;
    end else if (state_r == ST_EMIT) begin
      push             = need & ~fifo_full;
      push_item.kind   = copy_ph_r ? KIND_COPY : KIND_KEEP;
      push_item.target = i_r;
      push_item.source = copy_ph_r ? dupes_r[d_r] : '0;
      push_item.last   = copy_ph_r & copy_last;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:    if (job_vld) state_nxt = ST_S_RD;
      ST_S_RD:    state_nxt = ST_S_MUL;
      ST_S_MUL:   state_nxt = ST_S_ACC;
      ST_S_ACC:   state_nxt = i_end ? ST_SQ_GO : ST_S_RD;
      ST_SQ_GO:   state_nxt = ST_SQ_WAIT;
      ST_SQ_WAIT: if (mul_done) state_nxt = (s_r == '0) ? ST_HIST : ST_NE;
      ST_NE:      if (k_r == n_r) state_nxt = ST_HIST;
      ST_HIST:    state_nxt = (neff_r < (n_r >> 1)) ? ST_OF_GO : ST_SUMM;
      ST_OF_GO:   state_nxt = ST_OF_WAIT;
      ST_OF_WAIT: if (mul_done) state_nxt = ST_W_RD;
      ST_W_RD:    state_nxt = ST_W_MUL;
      ST_W_MUL:   state_nxt = ST_W_CMP;
      ST_W_CMP:   begin
        if (walk_go) state_nxt = ST_W_RD;
        else if (i_end) state_nxt = ST_SUMM;
      end
      ST_SUMM:    if (~fifo_full) state_nxt = (ndup_r == '0) ? ST_IDLE : ST_EMIT;
      ST_EMIT:    if (adv && need && copy_ph_r && copy_last) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  assign link.take        = (state_r == ST_IDLE) & job_vld;
  assign link.release_ram = (state_r == ST_S_ACC) & i_end;

  // state and history registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      for (int h = 0; h < HIST_LEN; h++) begin
        hist_r[h] <= RST_SIZE;
      end
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_HIST) begin
        for (int h = 0; h < HIST_LEN - 1; h++) begin
          hist_r[h] <= hist_r[h+1];
        end
        hist_r[HIST_LEN-1] <= neff_r;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        n_r      <= job.n;
        loaded_r <= job.loaded;
        off_r    <= job.off;
        i_r      <= '0;
        s_r      <= '0;
        q_r      <= '0;
        ndup_r   <= '0;
        res_r    <= 1'b0;
      end
      ST_S_MUL: begin
        s_r  <= s_r + SW'(v);
        sq_r <= (2*WB)'(v) * (2*WB)'(v);
      end
      ST_S_ACC: begin
        q_r <= q_r + QW'(sq_r);
        if (!i_end) i_r <= i_r + IW'(1);
      end
      ST_SQ_WAIT: begin
        s2_r   <= mul_prod[S2W-1:0];
        qi_r   <= EW'(q_r);
        k_r    <= NW'(1);
        zero_r <= s_r == '0;
        neff_r <= (s_r == '0) ? n_r : '0;
      end
      ST_NE: begin
        if (qi_r <= EW'(s2_r)) neff_r <= k_r;
        k_r  <= k_r + NW'(1);
        qi_r <= qi_r + EW'(q_r);
      end
      ST_HIST: begin
        res_r <= neff_r < (n_r >> 1);
      end
      ST_OF_GO: begin
        chosen_r <= '0;
        i_r      <= '0;
        j_r      <= '0;
      end
      ST_OF_WAIT: begin
        lhs_r <= CW'(mul_prod[SW+OFF_BITS-1:0]);
      end
      ST_W_MUL: begin
        cn_r <= (SW+NW)'(c_rdata) * (SW+NW)'(n_r);
      end
      ST_W_CMP: begin
        if (walk_go) begin
          j_r <= j_r + IW'(1);
        end else begin
          if (chosen_r[j_r]) begin
            dupes_r[ndup_r[IW-1:0]] <= j_r;
            ndup_r <= ndup_r + NW'(1);
          end else begin
            chosen_r[j_r] <= 1'b1;
          end
          i_r   <= i_r + IW'(1);
          lhs_r <= lhs_r + (CW'(s_r) << OFF_BITS);
        end
      end
      ST_SUMM: begin
        i_r       <= '0;
        d_r       <= '0;
        copy_ph_r <= 1'b0;
      end
      ST_EMIT: begin
        if (adv) begin
          if (copy_ph_r && need) d_r <= d_r + IW'(1);
          if (i_end) begin
            i_r       <= '0;
            copy_ph_r <= 1'b1;
          end else begin
            i_r <= i_r + IW'(1);
          end
        end
      end
      default: ;
    endcase
  end

  // two entry result queue
  res_t       fifo_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       pop;

  assign fifo_full = cnt_r == 2'd2;
  assign out_empty = cnt_r == 2'd0;
  assign pop       = out_pop & ~out_empty;
  assign out_item  = fifo_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) fifo_r[wp_r] <= push_item;
  end

endmodule

`default_nettype wire

[rtl/particle_systematic_resampler.sv]
// ----------------------------------------------------------------------------
// particle_systematic_resampler
// Effective sample size and systematic resampling over one round of weights.
// ----------------------------------------------------------------------------
// Usage: write the particle count on the cfg channel while idle (reset 10).
// Push one weight item per particle; the item with in_last_weight closes the
// round and its in_offset is the systematic offset in units of 1/65536.
// Weights load at one item per cycle while in_full is low. After the last
// item in_full stays high while the back end reads the weights, and the
// next round can load once they have been read.
// The round then computes the square of the sum (serial multiplier) and the
// effective size; if it resamples, offset*sum on the same multiplier and the
// systematic walk follow. Keep and copy entries are emitted in a scan over
// the particles that holds while the result queue is full.
// Results come out oldest first through a two entry queue: summary first,
// then keep and copy items; last_result marks the end of the round.
// If the receiver stalls, the back end holds in place and the front still
// loads the next round once the weights have been read.
// Reset: count 10, size history all 10, load count zero, queues empty.
// ----------------------------------------------------------------------------
`default_nettype none

module particle_systematic_resampler
  import psr_pkg::*;
#(
  parameter int WEIGHT_BITS = DEF_WEIGHT_BITS
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_push,
  output logic                        in_full,
  input  wire logic [WEIGHT_BITS-1:0] in_weight,
  input  wire logic [OFF_BITS-1:0]    in_offset,
  input  wire logic                   in_last_weight,
  output logic                        out_empty,
  input  wire logic                   out_pop,
  output logic      [1:0]             out_kind,
  output logic      [IW-1:0]          out_target,
  output logic      [IW-1:0]          out_source,
  output logic      [NW-1:0]          out_effective_size,
  output logic      [HSUM_W-1:0]      out_effective_sum3,
  output logic                        out_all_zero,
  output logic                        out_resampled,
  output logic                        out_last_result,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [NW-1:0]          cfg_data
);

  logic [NW-1:0]          count_r;
  logic                   w_we;
  logic [IW-1:0]          w_waddr, w_raddr;
  logic [WEIGHT_BITS-1:0] w_wdata, w_rdata;
  logic                   job_vld;
  job_t                   job;
  bk2fe_t                 link;
  res_t                   item;

  // configuration register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= RST_COUNT;
    end else if (cfg_valid && cfg_ready) begin
      count_r <= cfg_data;
    end
  end

  psr_front #(.WEIGHT_BITS(WEIGHT_BITS)) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_weight      (in_weight),
    .in_offset      (in_offset),
    .in_last_weight (in_last_weight),
    .in_full        (in_full),
    .count          (count_r),
    .ram_we         (w_we),
    .ram_waddr      (w_waddr),
    .ram_wdata      (w_wdata),
    .job_vld        (job_vld),
    .job            (job),
    .link           (link)
  );

  // weight store
  psr_ram #(.W(WEIGHT_BITS), .D(MAX_P)) u_wram (
    .clk   (clk),
    .we    (w_we),
    .waddr (w_waddr),
    .wdata (w_wdata),
    .raddr (w_raddr),
    .rdata (w_rdata)
  );

  psr_back #(.WEIGHT_BITS(WEIGHT_BITS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_vld   (job_vld),
    .job       (job),
    .link      (link),
    .w_raddr   (w_raddr),
    .w_rdata   (w_rdata),
    .out_item  (item),
    .out_empty (out_empty),
    .out_pop   (out_pop)
  );

  // result fields
  assign out_kind           = item.kind;
  assign out_target         = item.target;
  assign out_source         = item.source;
  assign out_effective_size = item.size;
  assign out_effective_sum3 = item.sum3;
  assign out_all_zero       = item.zero;
  assign out_resampled      = item.res;
  assign out_last_result    = item.last;

  // a closed round blocks further loading at once
  a_last_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_push && !in_full && in_last_weight) |=> in_full)
    else $error("input not blocked after last item");

  // a copy never targets its own source
  a_copy_distinct: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_kind == KIND_COPY) |-> (out_target != out_source))
    else $error("copy item with equal target and source");

  // all-zero rounds never resample
  a_zero_no_res: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_all_zero) |-> !out_resampled)
    else $error("resampled with all weights zero");

  // keep and copy items only appear in resampled rounds
  a_entry_res: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_kind != KIND_SUMMARY) |-> out_resampled)
    else $error("entry item in a round without resampling");

endmodule

`default_nettype wire

[tb/particle_systematic_resampler_test.sv]
// ----------------------------------------------------------------------------
// particle_systematic_resampler_test
// Drives rounds of particle weights and checks the summary, keep and copy
// items against a behavioral predictor of effective size and resampling.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module particle_systematic_resampler_test;
  import psr_pkg::*;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_push = 1'b0;
  logic                in_full;
  logic [31:0]         in_weight = '0;
  logic [OFF_BITS-1:0] in_offset = '0;
  logic                in_last_weight = 1'b0;
  logic                out_empty;
  logic                out_pop = 1'b0;
  logic [1:0]          out_kind;
  logic [IW-1:0]       out_target;
  logic [IW-1:0]       out_source;
  logic [NW-1:0]       out_effective_size;
  logic [HSUM_W-1:0]   out_effective_sum3;
  logic                out_all_zero;
  logic                out_resampled;
  logic                out_last_result;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [NW-1:0]       cfg_data = '0;

  particle_systematic_resampler u_top (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full), .in_weight(in_weight),
    .in_offset(in_offset), .in_last_weight(in_last_weight),
    .out_empty(out_empty), .out_pop(out_pop), .out_kind(out_kind),
    .out_target(out_target), .out_source(out_source),
    .out_effective_size(out_effective_size),
    .out_effective_sum3(out_effective_sum3), .out_all_zero(out_all_zero),
    .out_resampled(out_resampled), .out_last_result(out_last_result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // predictor state
  logic [31:0]   weights_held [MAX_P];
  logic [NW-1:0] size_hist [HIST_LEN];
  int unsigned   weights_loaded;
  logic [NW-1:0] count_reg;

  res_t expected_items [$];
  int   mismatch_count = 0;
  int   rounds_closed = 0;
  int   resample_rounds = 0;
  int   copy_items_seen = 0;
  int   items_sent = 0;
  longint cycle_count = 0;

  // idling controls
  int  idle_pct_in = 7;
  int  idle_pct_out = 7;
  int  hold_off_len = 0;
  int  hold_requests = 0;
  int  hold_seen = 0;
  int  hold_left = 0;

  // append one expected result item
  task automatic queue_expected(input res_t r);
    expected_items.insert(expected_items.size(), r);
  endtask

  // ---------------------------------------------------------------------------
  // predictor: stores weights, computes results on the closing item
  task automatic predict_weight(input logic [31:0] w, input logic [15:0] off,
                                input logic lst);
    int unsigned n, i, j, nd;
    logic [63:0]  s;
    logic [127:0] q, s2, lhs, rhs;
    logic [63:0]  cum [MAX_P];
    logic [63:0]  v, pos, scale;
    logic [NW-1:0] neff;
    logic [HSUM_W-1:0] hsum;
    logic zero, rs;
    bit picked [MAX_P];
    logic [IW-1:0] dupes [MAX_P];
    res_t r;
    n = clamp_count(count_reg);
    if (weights_loaded < n) begin
      weights_held[weights_loaded] = w;
      weights_loaded++;
    end
    if (!lst) return;
    s = 0; q = 0;
    for (i = 0; i < n; i++) begin
      v = (i < weights_loaded) ? weights_held[i] : 0;
      s += v;
      cum[i] = s;
      q += 128'(v) * 128'(v);
    end
    zero = (s == 0);
    if (zero) neff = NW'(n);
    else begin
      s2 = 128'(s) * 128'(s);
      neff = 0;
      for (i = 1; i <= n; i++)
        if (q * 128'(i) <= s2) neff = NW'(i);
    end
    for (i = 0; i + 1 < HIST_LEN; i++) size_hist[i] = size_hist[i+1];
    size_hist[HIST_LEN-1] = neff;
    hsum = 0;
    for (i = 0; i < HIST_LEN; i++) hsum += HSUM_W'(size_hist[i]);
    rs = (neff < NW'(n / 2));
    r = '{kind: KIND_SUMMARY, target: '0, source: '0, size: neff, sum3: hsum,
          zero: zero, res: rs, last: 1'b0};
    queue_expected(r);
    rounds_closed++;
    if (rs) begin
      resample_rounds++;
      nd = 0; j = 0;
      for (i = 0; i < MAX_P; i++) picked[i] = 0;
      scale = 64'(n) << OFF_BITS;
      for (i = 0; i < n; i++) begin
        pos = (64'(i) << OFF_BITS) + 64'(off);
        lhs = 128'(pos) * 128'(s);
        forever begin
          rhs = 128'(cum[j]) * 128'(scale);
          if (j + 1 < n && rhs <= lhs) j++;
          else break;
        end
        if (picked[j]) begin dupes[nd] = IW'(j); nd++; end
        else picked[j] = 1;
      end
      if (nd > 0) begin
        for (i = 0; i < n; i++)
          if (picked[i]) begin
            r.kind = KIND_KEEP; r.target = IW'(i); r.source = '0;
            queue_expected(r);
          end
        j = 0;
        for (i = 0; i < n && j < nd; i++)
          if (!picked[i]) begin
            r.kind = KIND_COPY; r.target = IW'(i); r.source = dupes[j];
            queue_expected(r);
            j++;
          end
      end
    end
    expected_items[$].last = 1'b1;
    weights_loaded = 0;
  endtask

  // ---------------------------------------------------------------------------
  // sender: one weight item, with random idle before it
  task automatic send_weight(input logic [31:0] w, input logic [15:0] off,
                             input logic lst);
    while ($urandom_range(99, 0) < idle_pct_in) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push <= 1'b1;
    in_weight <= w;
    in_offset <= off;
    in_last_weight <= lst;
    @(posedge clk);
    while (in_full) @(posedge clk);
    predict_weight(w, off, lst);
    items_sent++;
  endtask

  // one round of count weights, last on the final one
  task automatic send_round(input int unsigned cnt, input int mode);
    logic [31:0] w;
    for (int unsigned i = 0; i < cnt; i++) begin
      case (mode)
        0: w = $urandom;
        1: w = $urandom_range(3, 0);
        2: w = ($urandom_range(3, 0) == 0) ? $urandom : 32'(0);
        default: w = $urandom_range(1000, 0);
      endcase
      send_weight(w, 16'($urandom), i == cnt - 1);
    end
  endtask

  task automatic wait_drained();
    in_push <= 1'b0;
    while (expected_items.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic write_count(input logic [NW-1:0] c);
    cfg_valid <= 1'b1;
    cfg_data <= c;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    count_reg = c;
  endtask

  // ---------------------------------------------------------------------------
  // result receiver and checker
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (rst_n && out_pop && !out_empty) begin
      if (expected_items.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected item: kind %0d target %0d", out_kind, out_target);
      end else begin
        res_t e;
        e = expected_items.pop_front();
        if (out_kind == KIND_COPY) copy_items_seen++;
        if (out_kind != e.kind || out_target != e.target ||
            out_source != e.source || out_effective_size != e.size ||
            out_effective_sum3 != e.sum3 || out_all_zero != e.zero ||
            out_resampled != e.res || out_last_result != e.last) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("mismatch: exp k%0d t%0d s%0d n%0d h%0d z%0d r%0d l%0d",
                     e.kind, e.target, e.source, e.size, e.sum3, e.zero, e.res,
                     e.last);
            $display("          got k%0d t%0d s%0d n%0d h%0d z%0d r%0d l%0d",
                     out_kind, out_target, out_source, out_effective_size,
                     out_effective_sum3, out_all_zero, out_resampled,
                     out_last_result);
          end
        end
      end
    end
  end

  // receiver pacing, with long hold-off stretches on request
  always @(posedge clk) begin
    if (hold_requests != hold_seen) begin
      hold_seen <= hold_requests;
      hold_left <= hold_off_len;
      out_pop <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_pop <= 1'b0;
    end else begin
      out_pop <= ($urandom_range(99, 0) >= idle_pct_out);
    end
  end

  // run limit
  always @(posedge clk)
    if (cycle_count > 2000000) begin
      $display("CHECKS FAILED");
      $finish;
    end

  // ---------------------------------------------------------------------------
  // tests
  task automatic test_directed();
    write_count(NW'(4));
    send_weight(32'd0, 16'd0, 1'b0); send_weight(32'd0, 16'd0, 1'b0);
    send_weight(32'd0, 16'd0, 1'b0); send_weight(32'd0, 16'hFFFF, 1'b1);
    // one heavy particle: full resampling onto it
    send_weight(32'hFFFF_FFFF, 16'hFFFF, 1'b0); send_weight(32'd0, 16'd0, 1'b0);
    send_weight(32'd0, 16'd0, 1'b0); send_weight(32'd1, 16'd0, 1'b1);
    // early last item, then surplus items
    send_weight(32'hFFFF_FFFF, 16'h8000, 1'b1);
    send_weight(32'd5, 16'd0, 1'b0); send_weight(32'd1, 16'd0, 1'b0);
    send_weight(32'd1, 16'd0, 1'b0); send_weight(32'd1, 16'd0, 1'b0);
    send_weight(32'd7, 16'd0, 1'b0); send_weight(32'd9, 16'h1234, 1'b1);
    wait_drained();
    write_count(NW'(0));
    send_weight(32'h8000_0000, 16'h5555, 1'b1);
    wait_drained();
    write_count(NW'(63));
    send_round(32, 2);
    wait_drained();
  endtask

  task automatic test_random_rounds(input int unsigned quota);
    int unsigned start;
    start = items_sent;
    while (items_sent - start < quota) begin
      if ($urandom_range(9, 0) == 0) begin
        wait_drained();
        write_count(NW'($urandom_range(63, 0)));
      end
      if ($urandom_range(9, 0) == 0)
        send_weight($urandom, 16'($urandom), $urandom_range(1, 0));
      else
        send_round(clamp_count(count_reg) - (($urandom_range(7, 0) == 0) ? 1 : 0),
                   $urandom_range(3, 0));
    end
  endtask

  task automatic test_back_pressure();
    wait_drained();
    write_count(NW'(2));
    hold_off_len = 300;
    hold_requests++;
    repeat (6) send_round(2, 2);
    // sender pause until all results are in
    wait_drained();
    send_round(2, 1);
  endtask

  task automatic test_no_idle();
    idle_pct_in = 0;
    idle_pct_out = 0;
    test_random_rounds(60);
    idle_pct_in = 7;
    idle_pct_out = 7;
  endtask

  initial begin
    for (int i = 0; i < HIST_LEN; i++) size_hist[i] = RST_SIZE;
    count_reg = RST_COUNT;
    weights_loaded = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_rounds(150);
    test_back_pressure();
    test_no_idle();
    wait_drained();
    write_count(NW'(1));
    test_random_rounds(40);
    wait_drained();
    write_count(NW'(32));
    test_random_rounds(60);
    // flush any partial round so nothing stays pending
    send_weight(32'd3, 16'd0, 1'b1);
    wait_drained();
    $display("%0d items sent, %0d rounds closed, %0d resampled, %0d copy items",
             items_sent, rounds_closed, resample_rounds, copy_items_seen);
    if (mismatch_count == 0 && expected_items.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
